// File: rtl/tfn_pkg.sv
// tfn_pkg: widths, item types and shared constants for the triangle face normal block
// used by every module under rtl; depends on nothing
package tfn_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int NORMAL_WIDTH = 32;

   localparam int CW    = COORD_WIDTH;
   localparam int NW    = NORMAL_WIDTH;
   localparam int XW    = 2 * CW + 1;          // cross product magnitude
   localparam int PW    = 2 * CW;              // edge product magnitude
   localparam int LW    = $clog2(XW + 1);      // bit length of a cross magnitude
   localparam int NB    = 31;                  // bits of a scaled magnitude
   localparam int SW    = 2 * NB + 2;          // sum of squares
   localparam int RW    = SW / 2;              // square root
   localparam int FW    = NW - 2;              // fraction bits of the normal
   localparam int QW    = FW + 1;              // quotient magnitude
   localparam int NUMW  = NB + FW + 1;         // dividend
   localparam int IPS   = 2;                   // iterations per stage
   localparam int SQ_ST = (RW + IPS - 1) / IPS;
   localparam int DV_ST = (QW + IPS - 1) / IPS;

   typedef struct packed {
      logic signed [CW-1:0] a_x;
      logic signed [CW-1:0] a_y;
      logic signed [CW-1:0] a_z;
      logic signed [CW-1:0] b_x;
      logic signed [CW-1:0] b_y;
      logic signed [CW-1:0] b_z;
      logic signed [CW-1:0] c_x;
      logic signed [CW-1:0] c_y;
      logic signed [CW-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic signed [NW-1:0] normal_x;
      logic signed [NW-1:0] normal_y;
      logic signed [NW-1:0] normal_z;
      logic                 degenerate;
   } rsp_type;

   typedef struct packed {
      logic [2:0][XW-1:0] mag;
      logic [2:0]         neg;
   } cross_type;

   typedef struct packed {
      logic [2:0][NB-1:0] m;
      logic [2:0]         neg;
      logic               degen;
   } side_type;

endpackage

// File: rtl/tfn_cross.sv
// tfn_cross: edges, edge products and cross product in sign-magnitude, three stages
// depends on tfn_pkg
module tfn_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tfn_pkg::req_type   in_data,
   output logic               out_valid,
   output tfn_pkg::cross_type out_data
);

   logic [5:0][tfn_pkg::CW-1:0] emag_ff, emag_in;
   logic [5:0]                  eneg_ff, eneg_in;
   logic [5:0][tfn_pkg::PW-1:0] prod_ff, prod_in;
   logic [5:0]                  pneg_ff, pneg_in;
   tfn_pkg::cross_type          cr_ff, cr_in;
   logic [2:0]                  v_ff;

   function automatic logic [tfn_pkg::CW:0] edge_of(logic [tfn_pkg::CW-1:0] p,
                                                   logic [tfn_pkg::CW-1:0] q);
      return {p[tfn_pkg::CW-1], p} - {q[tfn_pkg::CW-1], q};
   endfunction

   always_comb begin
      logic [5:0][tfn_pkg::CW:0] e;
      e[0] = edge_of(in_data.b_x, in_data.a_x);
      e[1] = edge_of(in_data.b_y, in_data.a_y);
      e[2] = edge_of(in_data.b_z, in_data.a_z);
      e[3] = edge_of(in_data.c_x, in_data.a_x);
      e[4] = edge_of(in_data.c_y, in_data.a_y);
      e[5] = edge_of(in_data.c_z, in_data.a_z);
      for (int i = 0; i < 6; i++) begin
         eneg_in[i] = e[i][tfn_pkg::CW];
         emag_in[i] = eneg_in[i] ? tfn_pkg::CW'(-e[i]) : e[i][tfn_pkg::CW-1:0];
      end
   end

   // pair order: e1y*e2z, e1z*e2y, e1z*e2x, e1x*e2z, e1x*e2y, e1y*e2x
   always_comb begin
      prod_in[0] = tfn_pkg::PW'(emag_ff[1]) * tfn_pkg::PW'(emag_ff[5]);
      prod_in[1] = tfn_pkg::PW'(emag_ff[2]) * tfn_pkg::PW'(emag_ff[4]);
      prod_in[2] = tfn_pkg::PW'(emag_ff[2]) * tfn_pkg::PW'(emag_ff[3]);
      prod_in[3] = tfn_pkg::PW'(emag_ff[0]) * tfn_pkg::PW'(emag_ff[5]);
      prod_in[4] = tfn_pkg::PW'(emag_ff[0]) * tfn_pkg::PW'(emag_ff[4]);
      prod_in[5] = tfn_pkg::PW'(emag_ff[1]) * tfn_pkg::PW'(emag_ff[3]);
      pneg_in[0] = eneg_ff[1] ^ eneg_ff[5];
      pneg_in[1] = eneg_ff[2] ^ eneg_ff[4];
      pneg_in[2] = eneg_ff[2] ^ eneg_ff[3];
      pneg_in[3] = eneg_ff[0] ^ eneg_ff[5];
      pneg_in[4] = eneg_ff[0] ^ eneg_ff[4];
      pneg_in[5] = eneg_ff[1] ^ eneg_ff[3];
   end

   always_comb begin
      logic [tfn_pkg::XW-1:0] u1, u2;
      for (int k = 0; k < 3; k++) begin
         u1 = tfn_pkg::XW'(prod_ff[2*k]);
         u2 = tfn_pkg::XW'(prod_ff[2*k+1]);
         if (pneg_ff[2*k] != pneg_ff[2*k+1]) begin
            cr_in.mag[k] = u1 + u2;
            cr_in.neg[k] = pneg_ff[2*k];
         end else if (u1 >= u2) begin
            cr_in.mag[k] = u1 - u2;
            cr_in.neg[k] = pneg_ff[2*k];
         end else begin
            cr_in.mag[k] = u2 - u1;
            cr_in.neg[k] = !pneg_ff[2*k];
         end
         if (cr_in.mag[k] == '0) begin
            cr_in.neg[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
      if (en) begin
         emag_ff <= emag_in;
         eneg_ff <= eneg_in;
         prod_ff <= prod_in;
         pneg_ff <= pneg_in;
         cr_ff   <= cr_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_data  = cr_ff;

endmodule

// File: rtl/tfn_scale.sv
// tfn_scale: bit length, scaling to 31-bit magnitudes, squares and their sum, four stages
// depends on tfn_pkg
module tfn_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  tfn_pkg::cross_type     in_data,
   output logic                   out_valid,
   output tfn_pkg::side_type      out_side,
   output logic [tfn_pkg::SW-1:0] out_sum
);

   tfn_pkg::cross_type              cr_ff;
   logic [tfn_pkg::LW-1:0]          len_ff, len_in;
   tfn_pkg::side_type               sd1_ff, sd1_in, sd2_ff, sd3_ff;
   logic [2:0][2*tfn_pkg::NB-1:0]   sq_ff, sq_in;
   logic [tfn_pkg::SW-1:0]          sum_ff, sum_in;
   logic [3:0]                      v_ff;

   always_comb begin
      logic [tfn_pkg::XW-1:0] orv;
      orv    = in_data.mag[0] | in_data.mag[1] | in_data.mag[2];
      len_in = '0;
      for (int i = 0; i < tfn_pkg::XW; i++) begin
         if (orv[i]) begin
            len_in = tfn_pkg::LW'(i + 1);
         end
      end
   end

   always_comb begin
      logic [tfn_pkg::XW-1:0] sh;
      for (int k = 0; k < 3; k++) begin
         if (len_ff > tfn_pkg::LW'(tfn_pkg::NB)) begin
            sh = cr_ff.mag[k] >> (len_ff - tfn_pkg::LW'(tfn_pkg::NB));
         end else begin
            sh = cr_ff.mag[k] << (tfn_pkg::LW'(tfn_pkg::NB) - len_ff);
         end
         sd1_in.m[k] = sh[tfn_pkg::NB-1:0];
      end
      sd1_in.neg   = cr_ff.neg;
      sd1_in.degen = (len_ff == '0);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = (2*tfn_pkg::NB)'(sd1_ff.m[k]) * (2*tfn_pkg::NB)'(sd1_ff.m[k]);
      end
      sum_in = tfn_pkg::SW'(sq_ff[0]) + tfn_pkg::SW'(sq_ff[1]) + tfn_pkg::SW'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
      if (en) begin
         cr_ff  <= in_data;
         len_ff <= len_in;
         sd1_ff <= sd1_in;
         sq_ff  <= sq_in;
         sd2_ff <= sd1_ff;
         sum_ff <= sum_in;
         sd3_ff <= sd2_ff;
      end
   end

   assign out_valid = v_ff[3];
   assign out_side  = sd3_ff;
   assign out_sum   = sum_ff;

endmodule

// File: rtl/tfn_isqrt.sv
// tfn_isqrt: pipelined digit-by-digit integer square root, two result bits a stage
// depends on tfn_pkg
module tfn_isqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  tfn_pkg::side_type      in_side,
   input  logic [tfn_pkg::SW-1:0] in_sum,
   output logic                   out_valid,
   output tfn_pkg::side_type      out_side,
   output logic [tfn_pkg::RW-1:0] out_root
);

   localparam int REMW = tfn_pkg::RW + 3;

   typedef struct packed {
      logic [tfn_pkg::SW-1:0] x;
      logic [REMW-1:0]        rem;
      logic [tfn_pkg::RW-1:0] root;
   } sq_type;

   sq_type            st_ff [tfn_pkg::SQ_ST];
   sq_type            st_in [tfn_pkg::SQ_ST];
   tfn_pkg::side_type sd_ff [tfn_pkg::SQ_ST];
   logic [tfn_pkg::SQ_ST-1:0] v_ff;

   function automatic sq_type sq_step(sq_type a);
      sq_type          b;
      logic [REMW-1:0] r2;
      logic [REMW-1:0] tr;
      r2  = {a.rem[REMW-3:0], a.x[tfn_pkg::SW-1:tfn_pkg::SW-2]};
      tr  = {1'b0, a.root, 2'b01};
      b.x = a.x << 2;
      if (r2 >= tr) begin
         b.rem  = r2 - tr;
         b.root = {a.root[tfn_pkg::RW-2:0], 1'b1};
      end else begin
         b.rem  = r2;
         b.root = {a.root[tfn_pkg::RW-2:0], 1'b0};
      end
      return b;
   endfunction

   for (genvar s = 0; s < tfn_pkg::SQ_ST; s++) begin : g_st
      sq_type src;
      if (s == 0) begin : g_first
         assign src = '{x: in_sum, rem: '0, root: '0};
      end else begin : g_next
         assign src = st_ff[s-1];
      end
      always_comb begin
         sq_type cur;
         cur = src;
         for (int k = 0; k < tfn_pkg::IPS; k++) begin
            if (s * tfn_pkg::IPS + k < tfn_pkg::RW) begin
               cur = sq_step(cur);
            end
         end
         st_in[s] = cur;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[s] <= st_in[s];
            sd_ff[s] <= (s == 0) ? in_side : sd_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[tfn_pkg::SQ_ST-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[tfn_pkg::SQ_ST-1];
   assign out_side  = sd_ff[tfn_pkg::SQ_ST-1];
   assign out_root  = st_ff[tfn_pkg::SQ_ST-1].root;

endmodule

// File: rtl/tfn_div.sv
// tfn_div: three-lane pipelined restoring divider, two quotient bits a stage, then sign
// and degenerate handling into the result register; depends on tfn_pkg
module tfn_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  tfn_pkg::side_type      in_side,
   input  logic [tfn_pkg::RW-1:0] in_root,
   output logic                   out_valid,
   output tfn_pkg::rsp_type       out_data
);

   typedef struct packed {
      logic [2:0][tfn_pkg::RW:0]   rem;
      logic [2:0][tfn_pkg::QW-1:0] low;
      logic [2:0][tfn_pkg::QW-1:0] q;
      logic [tfn_pkg::RW-1:0]      den;
      logic [2:0]                  neg;
      logic                        degen;
   } dv_type;

   dv_type                    st_ff [tfn_pkg::DV_ST];
   dv_type                    st_in [tfn_pkg::DV_ST];
   dv_type                    init;
   logic [tfn_pkg::DV_ST-1:0] v_ff;
   logic                      ov_ff;
   tfn_pkg::rsp_type          rsp_ff, rsp_in;

   function automatic dv_type dv_step(dv_type a);
      dv_type               b;
      logic [tfn_pkg::RW:0] r1;
      b = a;
      for (int k = 0; k < 3; k++) begin
         r1       = {a.rem[k][tfn_pkg::RW-1:0], a.low[k][tfn_pkg::QW-1]};
         b.low[k] = a.low[k] << 1;
         if (r1 >= {1'b0, a.den}) begin
            b.rem[k] = r1 - {1'b0, a.den};
            b.q[k]   = {a.q[k][tfn_pkg::QW-2:0], 1'b1};
         end else begin
            b.rem[k] = r1;
            b.q[k]   = {a.q[k][tfn_pkg::QW-2:0], 1'b0};
         end
      end
      return b;
   endfunction

   always_comb begin
      logic [tfn_pkg::NUMW-1:0] num;
      init.den   = in_root;
      init.neg   = in_side.neg;
      init.degen = in_side.degen;
      init.q     = '0;
      for (int k = 0; k < 3; k++) begin
         num = (tfn_pkg::NUMW'(in_side.m[k]) << tfn_pkg::FW)
             + tfn_pkg::NUMW'(in_root >> 1);
         init.rem[k] = (tfn_pkg::RW+1)'(num >> tfn_pkg::QW);
         init.low[k] = num[tfn_pkg::QW-1:0];
      end
   end

   for (genvar s = 0; s < tfn_pkg::DV_ST; s++) begin : g_st
      dv_type src;
      if (s == 0) begin : g_first
         assign src = init;
      end else begin : g_next
         assign src = st_ff[s-1];
      end
      always_comb begin
         dv_type cur;
         cur = src;
         for (int k = 0; k < tfn_pkg::IPS; k++) begin
            if (s * tfn_pkg::IPS + k < tfn_pkg::QW) begin
               cur = dv_step(cur);
            end
         end
         st_in[s] = cur;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   always_comb begin
      dv_type                   fin;
      logic [2:0][tfn_pkg::NW-1:0] val;
      logic [tfn_pkg::NW-1:0]   qe;
      fin = st_ff[tfn_pkg::DV_ST-1];
      for (int k = 0; k < 3; k++) begin
         qe     = tfn_pkg::NW'(fin.q[k]);
         val[k] = fin.degen ? '0 : (fin.neg[k] ? -qe : qe);
      end
      rsp_in.normal_x   = val[0];
      rsp_in.normal_y   = val[1];
      rsp_in.normal_z   = val[2];
      rsp_in.degenerate = fin.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= {v_ff[tfn_pkg::DV_ST-2:0], in_valid};
         ov_ff <= v_ff[tfn_pkg::DV_ST-1];
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_data  = rsp_ff;

endmodule

// File: rtl/triangle_face_normal.sv
// triangle_face_normal: top level, unit face normal of one triangle per cycle while req_stall is low
// depends on tfn_pkg, tfn_cross, tfn_scale, tfn_isqrt, tfn_div
//
// An item on the req_ channel is one triangle: three vertices in signed Q16.16. It is
// taken at a clock edge with req_valid high and req_stall low. The rsp_ channel returns
// one item per triangle, in order: the unit normal of (b-a) x (c-a) in signed Q2.30 and
// a degenerate flag, which is set with an all-zero normal when the cross product is zero.
// An accepted item passes through the cross product, scaling and the sum of squares, the
// square root (two root bits a stage), the three dividers (two quotient bits a stage)
// and the result register, in that order, before rsp_valid is raised for it.
// Throughput is one triangle per cycle while req_stall is low; each stage holds one item.
// The whole pipeline advances together: while the result is held by rsp_stall every
// stage holds, req_stall is raised and no item is lost or repeated. While the result
// register is empty every stage advances, even with rsp_stall high.
// Reset is synchronous and clears all valid bits; no item is in flight afterwards.
module triangle_face_normal (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tfn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tfn_pkg::rsp_type rsp_data
);

   logic                   en;
   logic                   cr_valid, sc_valid, sq_valid;
   tfn_pkg::cross_type     cr_data;
   tfn_pkg::side_type      sc_side, sq_side;
   logic [tfn_pkg::SW-1:0] sc_sum;
   logic [tfn_pkg::RW-1:0] sq_root;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   tfn_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (cr_valid),
      .out_data  (cr_data)
   );

   tfn_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cr_valid),
      .in_data   (cr_data),
      .out_valid (sc_valid),
      .out_side  (sc_side),
      .out_sum   (sc_sum)
   );

   tfn_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sc_valid),
      .in_side   (sc_side),
      .in_sum    (sc_sum),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   tfn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_side   (sq_side),
      .in_root   (sq_root),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   localparam logic signed [tfn_pkg::NW-1:0] ONE  = tfn_pkg::NW'(1) << tfn_pkg::FW;
   localparam logic signed [tfn_pkg::NW-1:0] MONE = -ONE;

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0)
      else $error("degenerate item with non-zero normal");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.normal_x <= ONE && rsp_data.normal_x >= MONE &&
         rsp_data.normal_y <= ONE && rsp_data.normal_y >= MONE &&
         rsp_data.normal_z <= ONE && rsp_data.normal_z >= MONE)
      else $error("normal component beyond unit range");

   a_hold_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("pipeline not held behind a stalled result");

   a_free_run : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule
